### src/i2c_register_master_core_assert.svh
// Assertion helpers for the register master core and its checker.
`ifndef I2C_REGISTER_MASTER_CORE_ASSERT_SVH
`define I2C_REGISTER_MASTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define I2CRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define I2CRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/i2crm_pkg.sv
`default_nettype none

package i2crm_pkg;

    typedef logic [4:0] t_phase;
    typedef logic [2:0] t_op;
    typedef logic [1:0] t_kind;
    typedef logic [1:0] t_stage;

    localparam t_phase PH_IDLE      = 5'd0;
    localparam t_phase PH_ST_A      = 5'd1;
    localparam t_phase PH_ST_B      = 5'd2;
    localparam t_phase PH_BIT_LO    = 5'd3;
    localparam t_phase PH_BIT_HI    = 5'd4;
    localparam t_phase PH_BIT_TAIL  = 5'd5;
    localparam t_phase PH_ACK_REL   = 5'd6;
    localparam t_phase PH_ACK_HI    = 5'd7;
    localparam t_phase PH_ACK_DONE  = 5'd8;
    localparam t_phase PH_WAIT_BYTE = 5'd9;
    localparam t_phase PH_RD_HI     = 5'd10;
    localparam t_phase PH_RD_LO     = 5'd11;
    localparam t_phase PH_MA_A      = 5'd12;
    localparam t_phase PH_MA_B      = 5'd13;
    localparam t_phase PH_MA_C      = 5'd14;
    localparam t_phase PH_SP_A      = 5'd15;
    localparam t_phase PH_SP_B      = 5'd16;
    localparam t_phase PH_SP_C      = 5'd17;

    localparam t_op OP_TICK  = 3'd0;
    localparam t_op OP_WRITE = 3'd1;
    localparam t_op OP_READ  = 3'd2;
    localparam t_op OP_PROBE = 3'd3;
    localparam t_op OP_BYTE  = 3'd4;

    localparam t_kind KIND_WRITE = 2'd0;
    localparam t_kind KIND_READ  = 2'd1;
    localparam t_kind KIND_PROBE = 2'd2;
    localparam t_kind KIND_FAIL  = 2'd3;

    localparam t_stage STAGE_ADDR  = 2'd0;
    localparam t_stage STAGE_REG   = 2'd1;
    localparam t_stage STAGE_DATA  = 2'd2;
    localparam t_stage STAGE_RADDR = 2'd3;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 4'd1;

    localparam logic [6:0]  DEV_ADDR_RST    = 7'd81;
    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd255;

    // output tdata layout
    localparam int OUT_W        = 16;
    localparam int OUT_SCL      = 0;
    localparam int OUT_SDA      = 1;
    localparam int OUT_RD_LO    = 2;
    localparam int OUT_RD_VALID = 10;
    localparam int OUT_NEED     = 11;
    localparam int OUT_BUSY     = 12;
    localparam int OUT_DONE     = 13;
    localparam int OUT_STATUS   = 14;

    typedef struct packed {
        t_op        op;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_sample;
    } t_item;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  bit_index;
        logic [7:0]  bytes_left;
        logic [7:0]  shift_reg;
        logic [15:0] wait_count;
        t_kind       kind;
        logic [7:0]  reg_latch;
        logic        scl_drv;
        logic        sda_drv;
        t_stage      stage;
    } t_state;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic       read_final;
        logic       done;
        logic       status;
    } t_result;

endpackage

`default_nettype wire

### src/i2crm_step.sv
`default_nettype none

module i2crm_step (
    input  var i2crm_pkg::t_item   i_item,
    input  var i2crm_pkg::t_state  i_state,
    input  wire logic [6:0]        i_dev_addr,
    input  wire logic [15:0]       i_ack_timeout,
    output var i2crm_pkg::t_state  o_state,
    output var i2crm_pkg::t_result o_result
);
    import i2crm_pkg::*;

    logic [3:0] bit_inc;
    logic [7:0] bytes_dec;
    logic [7:0] rd_shift;

    assign bit_inc   = 4'(i_state.bit_index + 4'd1);
    assign bytes_dec = 8'(i_state.bytes_left - 8'd1);
    assign rd_shift  = {i_state.shift_reg[6:0], i_item.sda_sample};

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_item.op)
            OP_WRITE, OP_READ, OP_PROBE: begin
                if (i_state.phase == PH_IDLE) begin
                    o_state.kind = 2'(i_item.op - OP_WRITE);
                    if (i_item.op != OP_PROBE && i_item.byte_count == 8'd0) begin
                        o_result.done   = 1'b1;
                        o_result.status = 1'b1;
                    end else begin
                        o_state.reg_latch  = i_item.reg_addr;
                        o_state.bytes_left = i_item.byte_count;
                        o_state.stage      = STAGE_ADDR;
                        o_state.shift_reg  = {i_dev_addr, 1'b0};
                        o_state.phase      = PH_ST_A;
                        o_state.scl_drv    = 1'b1;
                        o_state.sda_drv    = 1'b1;
                    end
                end
            end
            OP_BYTE: begin
                if (i_state.phase == PH_WAIT_BYTE) begin
                    o_state.shift_reg = i_item.write_byte;
                    o_state.stage     = STAGE_DATA;
                    o_state.bit_index = 4'd0;
                    o_state.phase     = PH_BIT_LO;
                    o_state.scl_drv   = 1'b0;
                    o_state.sda_drv   = i_item.write_byte[7];
                end
            end
            OP_TICK: begin
                case (i_state.phase)
                    PH_ST_A: begin
                        o_state.phase   = PH_ST_B;
                        o_state.scl_drv = 1'b1;
                        o_state.sda_drv = 1'b0;
                    end
                    PH_ST_B: begin
                        o_state.bit_index = 4'd0;
                        o_state.phase     = PH_BIT_LO;
                        o_state.scl_drv   = 1'b0;
                        o_state.sda_drv   = i_state.shift_reg[7];
                    end
                    PH_BIT_LO: begin
                        o_state.phase   = PH_BIT_HI;
                        o_state.scl_drv = 1'b1;
                        o_state.sda_drv = i_state.shift_reg[7];
                    end
                    PH_BIT_HI: begin
                        o_state.phase   = PH_BIT_TAIL;
                        o_state.scl_drv = 1'b0;
                        o_state.sda_drv = i_state.shift_reg[7];
                    end
                    PH_BIT_TAIL: begin
                        o_state.bit_index = bit_inc;
                        o_state.shift_reg = {i_state.shift_reg[6:0], 1'b0};
                        o_state.scl_drv   = 1'b0;
                        if (bit_inc < 4'd8) begin
                            o_state.phase   = PH_BIT_LO;
                            o_state.sda_drv = i_state.shift_reg[6];
                        end else begin
                            o_state.phase   = PH_ACK_REL;
                            o_state.sda_drv = 1'b1;
                        end
                    end
                    PH_ACK_REL: begin
                        o_state.wait_count = i_ack_timeout;
                        o_state.phase      = PH_ACK_HI;
                        o_state.scl_drv    = 1'b1;
                        o_state.sda_drv    = 1'b1;
                    end
                    PH_ACK_HI: begin
                        if (!i_item.sda_sample) begin
                            o_state.phase   = PH_ACK_DONE;
                            o_state.scl_drv = 1'b0;
                            o_state.sda_drv = 1'b1;
                        end else if (i_state.wait_count == 16'd0) begin
                            o_state.kind    = KIND_FAIL;
                            o_state.phase   = PH_SP_A;
                            o_state.scl_drv = 1'b0;
                            o_state.sda_drv = 1'b0;
                        end else begin
                            o_state.wait_count = 16'(i_state.wait_count - 16'd1);
                        end
                    end
                    PH_ACK_DONE: begin
                        case (i_state.stage)
                            STAGE_ADDR: begin
                                if (i_state.kind == KIND_PROBE) begin
                                    o_state.phase   = PH_SP_A;
                                    o_state.scl_drv = 1'b0;
                                    o_state.sda_drv = 1'b0;
                                end else begin
                                    o_state.shift_reg = i_state.reg_latch;
                                    o_state.stage     = STAGE_REG;
                                    o_state.bit_index = 4'd0;
                                    o_state.phase     = PH_BIT_LO;
                                    o_state.scl_drv   = 1'b0;
                                    o_state.sda_drv   = i_state.reg_latch[7];
                                end
                            end
                            STAGE_REG: begin
                                if (i_state.kind == KIND_READ) begin
                                    o_state.shift_reg = {i_dev_addr, 1'b1};
                                    o_state.stage     = STAGE_RADDR;
                                    o_state.phase     = PH_ST_A;
                                    o_state.scl_drv   = 1'b1;
                                    o_state.sda_drv   = 1'b1;
                                end else begin
                                    o_state.phase   = PH_WAIT_BYTE;
                                    o_state.scl_drv = 1'b0;
                                    o_state.sda_drv = 1'b1;
                                end
                            end
                            STAGE_DATA: begin
                                o_state.bytes_left = bytes_dec;
                                o_state.scl_drv    = 1'b0;
                                if (bytes_dec == 8'd0) begin
                                    o_state.phase   = PH_SP_A;
                                    o_state.sda_drv = 1'b0;
                                end else begin
                                    o_state.phase   = PH_WAIT_BYTE;
                                    o_state.sda_drv = 1'b1;
                                end
                            end
                            default: begin
                                o_state.bit_index = 4'd0;
                                o_state.shift_reg = 8'd0;
                                o_state.phase     = PH_RD_HI;
                                o_state.scl_drv   = 1'b1;
                                o_state.sda_drv   = 1'b1;
                            end
                        endcase
                    end
                    PH_RD_HI: begin
                        o_state.shift_reg = rd_shift;
                        if (i_state.bit_index == 4'd7) begin
                            o_result.read_valid = 1'b1;
                            o_result.read_data  = rd_shift;
                            o_result.read_final = (i_state.bytes_left == 8'd1);
                        end
                        o_state.phase   = PH_RD_LO;
                        o_state.scl_drv = 1'b0;
                        o_state.sda_drv = 1'b1;
                    end
                    PH_RD_LO: begin
                        o_state.bit_index = bit_inc;
                        if (bit_inc < 4'd8) begin
                            o_state.phase   = PH_RD_HI;
                            o_state.scl_drv = 1'b1;
                            o_state.sda_drv = 1'b1;
                        end else begin
                            o_state.phase   = PH_MA_A;
                            o_state.scl_drv = 1'b0;
                            o_state.sda_drv = !(i_state.bytes_left > 8'd1);
                        end
                    end
                    PH_MA_A: begin
                        o_state.phase   = PH_MA_B;
                        o_state.scl_drv = 1'b1;
                    end
                    PH_MA_B: begin
                        o_state.phase   = PH_MA_C;
                        o_state.scl_drv = 1'b0;
                    end
                    PH_MA_C: begin
                        o_state.bytes_left = bytes_dec;
                        if (bytes_dec == 8'd0) begin
                            o_state.phase   = PH_SP_A;
                            o_state.scl_drv = 1'b0;
                            o_state.sda_drv = 1'b0;
                        end else begin
                            o_state.bit_index = 4'd0;
                            o_state.phase     = PH_RD_HI;
                            o_state.scl_drv   = 1'b1;
                            o_state.sda_drv   = 1'b1;
                        end
                    end
                    PH_SP_A: begin
                        o_state.phase   = PH_SP_B;
                        o_state.scl_drv = 1'b1;
                        o_state.sda_drv = 1'b0;
                    end
                    PH_SP_B: begin
                        o_state.phase   = PH_SP_C;
                        o_state.scl_drv = 1'b1;
                        o_state.sda_drv = 1'b1;
                    end
                    PH_SP_C: begin
                        o_result.done   = 1'b1;
                        o_result.status = (i_state.kind == KIND_FAIL);
                        o_state.phase   = PH_IDLE;
                        o_state.scl_drv = 1'b1;
                        o_state.sda_drv = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### src/i2c_register_master_core.sv
// Byte-level I2C master for register write, register read and address probe.
// Input stream: each item carries an op in tuser. A begin op (write, read,
// probe) starts a transfer from idle; each tick op ends one bus half-period
// and carries the sampled SDA level; a write-byte op supplies the next data
// byte while need_byte is shown. Every accepted item yields exactly one
// result item with the SCL/SDA drive for the next half-period, any received
// byte (tlast marks the final one) and the busy, done and status flags.
// Config channel: index 0 device address, index 1 ACK timeout in ticks;
// always ready. The user must see that it is written only while no transfer
// runs; the block does not enforce this. Throughput is one item per clock.
// The result comes from the output register fed by the step logic. When the
// receiver stalls, the output register holds its item and s_axis_tready
// drops until it is taken; with tready high the input is taken every cycle.
// Synchronous reset returns the bus to idle with both lines released, the
// output empty and the config registers at defaults.
`default_nettype none

module i2c_register_master_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output var  logic                           s_axis_tready,
    // [7:0] reg_addr, [15:8] byte_count, [23:16] write_byte, [24] sda_sample
    input  wire logic [31:0]                    s_axis_tdata,
    // [2:0] op
    input  wire logic [2:0]                     s_axis_tuser,
    output var  logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [0] scl_level, [1] sda_level, [9:2] read_data, [10] read_valid,
    // [11] need_byte, [12] busy_res, [13] done_res, [14] status
    output var  logic [i2crm_pkg::OUT_W-1:0]    m_axis_tdata,
    output var  logic                           m_axis_tlast,
    input  wire logic                           i_cfg_valid,
    output var  logic                           o_cfg_ready,
    input  wire logic [i2crm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                    i_cfg_data
);
    import i2crm_pkg::*;

    t_state      r_state;
    t_state      n_state;
    t_result     n_result;
    t_item       in_item;
    logic [6:0]  r_dev_addr;
    logic [15:0] r_ack_timeout;
    logic        r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic [OUT_W-1:0] n_out_data;
    logic        r_out_last;
    logic        in_accept;

    assign in_item = {s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                      s_axis_tdata[23:16], s_axis_tdata[24]};

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    i2crm_step u_step (
        .i_item        (in_item),
        .i_state       (r_state),
        .i_dev_addr    (r_dev_addr),
        .i_ack_timeout (r_ack_timeout),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= '{phase: PH_IDLE, scl_drv: 1'b1, sda_drv: 1'b1, default: '0};
            r_out_valid   <= 1'b0;
            r_dev_addr    <= DEV_ADDR_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else begin
            if (in_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_DEV_ADDR) begin
                    r_dev_addr <= i_cfg_data[6:0];
                end else if (i_cfg_index == CFG_ACK_TIMEOUT) begin
                    r_ack_timeout <= i_cfg_data;
                end
            end
        end
    end

    always_comb begin
        n_out_data                 = '0;
        n_out_data[OUT_SCL]        = n_state.scl_drv;
        n_out_data[OUT_SDA]        = n_state.sda_drv;
        n_out_data[OUT_RD_LO +: 8] = n_result.read_data;
        n_out_data[OUT_RD_VALID]   = n_result.read_valid;
        n_out_data[OUT_NEED]       = (n_state.phase == PH_WAIT_BYTE);
        n_out_data[OUT_BUSY]       = (n_state.phase != PH_IDLE);
        n_out_data[OUT_DONE]       = n_result.done;
        n_out_data[OUT_STATUS]     = n_result.status;
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
            r_out_last <= n_result.read_final;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

### src/i2crm_checker.sv
`default_nettype none

`include "i2c_register_master_core_assert.svh"

module i2crm_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [i2crm_pkg::OUT_W-1:0] m_axis_tdata,
    input wire logic                        m_axis_tlast
);
    import i2crm_pkg::*;

    `I2CRM_ASSERT_NEXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")
    `I2CRM_ASSERT_NOW(a_done_idle, m_axis_tvalid && m_axis_tdata[OUT_DONE], !m_axis_tdata[OUT_BUSY] && !m_axis_tdata[OUT_NEED], "done while busy")
    `I2CRM_ASSERT_NOW(a_status_done, m_axis_tvalid && m_axis_tdata[OUT_STATUS], m_axis_tdata[OUT_DONE], "status without done")
    `I2CRM_ASSERT_NOW(a_read_busy, m_axis_tvalid && (m_axis_tdata[OUT_RD_VALID] || m_axis_tlast), m_axis_tdata[OUT_BUSY] && m_axis_tdata[OUT_RD_VALID] && !m_axis_tdata[OUT_DONE], "read byte outside transfer")
    `I2CRM_ASSERT_NOW(a_idle_lines, m_axis_tvalid && !m_axis_tdata[OUT_BUSY], m_axis_tdata[OUT_SCL] && m_axis_tdata[OUT_SDA], "lines held while idle")

endmodule

bind i2c_register_master_core i2crm_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i2crm_pkg::*;

    localparam t_op OP_SPARE_FIRST = 3'd5;
    localparam t_op OP_SPARE_LAST  = 3'd7;
    localparam int  QUIET_LIMIT    = 2000;
    localparam int  REPORT_LIMIT   = 200;
    localparam int  NO_REFUSAL     = -1;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] rdata;
        logic       rvalid;
        logic       rfinal;
        logic       need;
        logic       busy;
        logic       done;
        logic       status;
    } t_line_result;

    logic                 i_clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic [31:0]          in_data = '0;
    logic [2:0]           in_user = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    wire                  s_axis_tready;
    wire                  m_axis_tvalid;
    wire [OUT_W-1:0]      m_axis_tdata;
    wire                  m_axis_tlast;
    wire                  o_cfg_ready;

    i2c_register_master_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (in_data),
        .s_axis_tuser  (in_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // master state mirror
    logic [6:0]  dev_addr   = DEV_ADDR_RST;
    logic [15:0] ack_limit  = ACK_TIMEOUT_RST;
    t_phase      bus_phase  = PH_IDLE;
    logic [3:0]  bit_cnt    = '0;
    logic [7:0]  bytes_left = '0;
    logic [7:0]  shift_byte = '0;
    logic [15:0] ack_wait   = '0;
    t_kind       xfer_kind  = KIND_WRITE;
    logic [7:0]  reg_latch  = '0;
    logic        scl_drive  = 1'b1;
    logic        sda_drive  = 1'b1;
    t_stage      byte_stage = STAGE_ADDR;

    t_line_result expected_lines[$];
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;
    int xfers_ok       = 0;
    int xfers_failed   = 0;
    int bytes_read     = 0;

    function automatic void move_to(t_phase p, logic scl, logic sda);
        bus_phase = p;
        scl_drive = scl;
        sda_drive = sda;
    endfunction

    function automatic void start_byte();
        bit_cnt = '0;
        move_to(PH_BIT_LO, 1'b0, shift_byte[7]);
    endfunction

    function automatic t_line_result master_step(t_item it);
        t_line_result r;
        logic         held_sda;
        r = '0;
        held_sda = sda_drive;
        if (it.op == OP_WRITE || it.op == OP_READ || it.op == OP_PROBE) begin
            if (bus_phase == PH_IDLE) begin
                case (it.op)
                    OP_WRITE: xfer_kind = KIND_WRITE;
                    OP_READ:  xfer_kind = KIND_READ;
                    default:  xfer_kind = KIND_PROBE;
                endcase
                if (it.op != OP_PROBE && it.byte_count == '0) begin
                    r.done = 1'b1;
                    r.status = 1'b1;
                end else begin
                    reg_latch = it.reg_addr;
                    bytes_left = it.byte_count;
                    byte_stage = STAGE_ADDR;
                    shift_byte = {dev_addr, 1'b0};
                    move_to(PH_ST_A, 1'b1, 1'b1);
                end
            end
        end else if (it.op == OP_BYTE) begin
            if (bus_phase == PH_WAIT_BYTE) begin
                shift_byte = it.write_byte;
                byte_stage = STAGE_DATA;
                start_byte();
            end
        end else if (it.op == OP_TICK) begin
            case (bus_phase)
                PH_ST_A:     move_to(PH_ST_B, 1'b1, 1'b0);
                PH_ST_B:     start_byte();
                PH_BIT_LO:   move_to(PH_BIT_HI, 1'b1, shift_byte[7]);
                PH_BIT_HI:   move_to(PH_BIT_TAIL, 1'b0, shift_byte[7]);
                PH_BIT_TAIL: begin
                    bit_cnt = bit_cnt + 1'b1;
                    shift_byte = shift_byte << 1;
                    if (bit_cnt < 4'd8) move_to(PH_BIT_LO, 1'b0, shift_byte[7]);
                    else move_to(PH_ACK_REL, 1'b0, 1'b1);
                end
                PH_ACK_REL: begin
                    ack_wait = ack_limit;
                    move_to(PH_ACK_HI, 1'b1, 1'b1);
                end
                PH_ACK_HI: begin
                    if (!it.sda_sample) begin
                        move_to(PH_ACK_DONE, 1'b0, 1'b1);
                    end else if (ack_wait == '0) begin
                        xfer_kind = KIND_FAIL;
                        move_to(PH_SP_A, 1'b0, 1'b0);
                    end else begin
                        ack_wait = ack_wait - 1'b1;
                    end
                end
                PH_ACK_DONE: begin
                    case (byte_stage)
                        STAGE_ADDR: begin
                            if (xfer_kind == KIND_PROBE) begin
                                move_to(PH_SP_A, 1'b0, 1'b0);
                            end else begin
                                shift_byte = reg_latch;
                                byte_stage = STAGE_REG;
                                start_byte();
                            end
                        end
                        STAGE_REG: begin
                            if (xfer_kind == KIND_READ) begin
                                shift_byte = {dev_addr, 1'b1};
                                byte_stage = STAGE_RADDR;
                                move_to(PH_ST_A, 1'b1, 1'b1);
                            end else begin
                                move_to(PH_WAIT_BYTE, 1'b0, 1'b1);
                            end
                        end
                        STAGE_DATA: begin
                            bytes_left = bytes_left - 1'b1;
                            if (bytes_left == '0) move_to(PH_SP_A, 1'b0, 1'b0);
                            else move_to(PH_WAIT_BYTE, 1'b0, 1'b1);
                        end
                        default: begin
                            bit_cnt = '0;
                            shift_byte = '0;
                            move_to(PH_RD_HI, 1'b1, 1'b1);
                        end
                    endcase
                end
                PH_RD_HI: begin
                    shift_byte = {shift_byte[6:0], it.sda_sample};
                    if (bit_cnt == 4'd7) begin
                        r.rvalid = 1'b1;
                        r.rdata = shift_byte;
                        r.rfinal = (bytes_left == 8'd1);
                        bytes_read++;
                    end
                    move_to(PH_RD_LO, 1'b0, 1'b1);
                end
                PH_RD_LO: begin
                    bit_cnt = bit_cnt + 1'b1;
                    if (bit_cnt < 4'd8) move_to(PH_RD_HI, 1'b1, 1'b1);
                    else move_to(PH_MA_A, 1'b0, !(bytes_left > 8'd1));
                end
                PH_MA_A: move_to(PH_MA_B, 1'b1, held_sda);
                PH_MA_B: move_to(PH_MA_C, 1'b0, held_sda);
                PH_MA_C: begin
                    bytes_left = bytes_left - 1'b1;
                    if (bytes_left == '0) begin
                        move_to(PH_SP_A, 1'b0, 1'b0);
                    end else begin
                        bit_cnt = '0;
                        move_to(PH_RD_HI, 1'b1, 1'b1);
                    end
                end
                PH_SP_A: move_to(PH_SP_B, 1'b1, 1'b0);
                PH_SP_B: move_to(PH_SP_C, 1'b1, 1'b1);
                PH_SP_C: begin
                    r.done = 1'b1;
                    r.status = (xfer_kind == KIND_FAIL);
                    move_to(PH_IDLE, 1'b1, 1'b1);
                end
                default: ;
            endcase
        end
        if (r.done && r.status) xfers_failed++;
        else if (r.done) xfers_ok++;
        r.scl = scl_drive;
        r.sda = sda_drive;
        r.need = (bus_phase == PH_WAIT_BYTE);
        r.busy = (bus_phase != PH_IDLE);
        return r;
    endfunction

    // receiver side: random stalls, result checking
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic check_field(string label, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_line_result want;
        if (rst_n && m_axis_tvalid && out_ready) begin
            if (expected_lines.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, actual %0h", $time,
                         m_axis_tdata);
            end else begin
                want = expected_lines.pop_front();
                check_field("scl_level", want.scl, m_axis_tdata[OUT_SCL]);
                check_field("sda_level", want.sda, m_axis_tdata[OUT_SDA]);
                check_field("read_data", want.rdata, m_axis_tdata[OUT_RD_LO +: 8]);
                check_field("read_valid", want.rvalid, m_axis_tdata[OUT_RD_VALID]);
                check_field("read_final", want.rfinal, m_axis_tlast);
                check_field("need_byte", want.need, m_axis_tdata[OUT_NEED]);
                check_field("busy", want.busy, m_axis_tdata[OUT_BUSY]);
                check_field("done", want.done, m_axis_tdata[OUT_DONE]);
                check_field("status", want.status, m_axis_tdata[OUT_STATUS]);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && s_axis_tready) || (m_axis_tvalid && out_ready)
                || (cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // sender side
    function automatic t_item make_item(t_op op, logic [7:0] ra, logic [7:0] cnt,
                                        logic [7:0] wb, logic sda);
        t_item it;
        it.op = op;
        it.reg_addr = ra;
        it.byte_count = cnt;
        it.write_byte = wb;
        it.sda_sample = sda;
        return it;
    endfunction

    function automatic t_item random_item(t_op op);
        return make_item(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 1'($urandom_range(1)));
    endfunction

    task automatic send_item(t_item it, bit counted);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_user <= it.op;
        in_data <= {7'd0, it.sda_sample, it.write_byte, it.byte_count, it.reg_addr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_lines.push_back(master_step(it));
        if (counted) items_sent++;
    endtask

    // an item the block must ignore in its present phase
    task automatic send_noise();
        t_item it;
        int    pick;
        it = random_item(OP_TICK);
        pick = $urandom_range(2);
        if (pick == 0)
            it.op = t_op'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        else if (pick == 1)
            it.op = (bus_phase == PH_WAIT_BYTE || bus_phase == PH_IDLE) ? OP_TICK : OP_BYTE;
        else if (bus_phase == PH_IDLE)
            it.op = OP_BYTE;
        else
            it.op = t_op'($urandom_range(OP_PROBE, OP_WRITE));
        send_item(it, 1'b0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_DEV_ADDR) dev_addr = value[6:0];
        else if (idx == CFG_ACK_TIMEOUT) ack_limit = value;
    endtask

    // target behavior: acks late at random, refuses the ack numbered refuse_at
    task automatic run_transfer(t_op op, logic [7:0] ra, logic [7:0] cnt, int refuse_at,
                                int noise_pct);
        int   acks_done;
        logic sda;
        acks_done = 0;
        send_item(make_item(op, ra, cnt, 8'($urandom_range(255)), 1'($urandom_range(1))),
                  1'b1);
        while (bus_phase != PH_IDLE) begin
            if ($urandom_range(99) < noise_pct) send_noise();
            if (bus_phase == PH_WAIT_BYTE) begin
                send_item(random_item(OP_BYTE), 1'b1);
            end else begin
                sda = 1'($urandom_range(1));
                if (bus_phase == PH_ACK_HI) begin
                    if (acks_done == refuse_at || (ack_wait != '0 && $urandom_range(3) == 0)) begin
                        sda = 1'b1;
                    end else begin
                        sda = 1'b0;
                        acks_done++;
                    end
                end
                send_item(make_item(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                                    8'($urandom_range(255)), sda), 1'b1);
            end
        end
    endtask

    task automatic test_idle_items();
        send_item(make_item(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0), 1'b1);
        send_item(make_item(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b1);
        send_item(make_item(OP_BYTE, 8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b1);
        for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
            send_item(make_item(t_op'(k), 8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b1);
    endtask

    task automatic test_zero_length();
        send_item(make_item(OP_WRITE, 8'hFF, 8'h00, 8'hFF, 1'b1), 1'b1);
        send_item(make_item(OP_READ, 8'h00, 8'h00, 8'h00, 1'b0), 1'b1);
        run_transfer(OP_PROBE, 8'h00, 8'h00, NO_REFUSAL, 0);
    endtask

    task automatic test_absent_target();
        cfg_write(CFG_DEV_ADDR, 16'h007F);
        cfg_write(CFG_ACK_TIMEOUT, 16'h0000);
        run_transfer(OP_WRITE, 8'hFF, 8'hFF, 0, 0);
    endtask

    task automatic test_short_transfers();
        cfg_write(CFG_DEV_ADDR, 16'h0000);
        run_transfer(OP_READ, 8'h3C, 8'h02, NO_REFUSAL, 0);
    endtask

    task automatic test_busy_noise();
        cfg_write(CFG_ACK_TIMEOUT, 16'd4);
        run_transfer(OP_PROBE, 8'h81, 8'h7E, NO_REFUSAL, 20);
        run_transfer(OP_WRITE, 8'h42, 8'h02, NO_REFUSAL, 20);
    endtask

    task automatic test_random_mix(int send_pct, int stall_pct, logic [6:0] addr,
                                   logic [15:0] timeout, bit allow_abort, int quota);
        int         start;
        int         pick;
        int         refuse;
        logic [7:0] cnt;
        cfg_write(CFG_DEV_ADDR, {9'd0, addr});
        cfg_write(CFG_ACK_TIMEOUT, timeout);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        start = items_sent;
        while (items_sent - start < quota) begin
            if ($urandom_range(99) < 15) send_noise();
            pick = $urandom_range(99);
            refuse = NO_REFUSAL;
            if (pick < 5) begin
                cnt = '0;
            end else if (pick < 15 && allow_abort) begin
                cnt = 8'($urandom_range(255, 5));
                refuse = $urandom_range(2);
            end else begin
                cnt = 8'($urandom_range(4, 1));
            end
            if (allow_abort && refuse == NO_REFUSAL && $urandom_range(99) < 15)
                refuse = $urandom_range(3);
            run_transfer(t_op'($urandom_range(OP_PROBE, OP_WRITE)), 8'($urandom_range(255)),
                         cnt, refuse, 5);
        end
    endtask

    initial begin
        send_idle_pct = 8;
        recv_stall_pct = 54;
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_items();
        test_zero_length();
        test_absent_target();
        test_short_transfers();
        test_busy_noise();
        test_random_mix(8, 54, 7'($urandom_range(127)), 16'd2, 1'b1, 20);
        test_random_mix(54, 8, 7'd0, 16'hFFFF, 1'b0, 20);
        test_random_mix(0, 0, 7'($urandom_range(127)), 16'd0, 1'b1, 20);
        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("ran %0d transfer items: %0d transfers ended cleanly, %0d with error status",
                 items_sent, xfers_ok, xfers_failed);
        $display("received %0d bytes over three stall mixes and device/timeout extremes",
                 bytes_read);
        if (fail_count == 0 && expected_lines.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
